// ===== design/sfr_pkg.sv =====
// Package for the framed serial receiver: phase encoding, result kinds,
// register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_SUM  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NO_END   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDS_TYPE    = 2'd2;

    // Frame parsing phases, one-hot
    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_TYPE    = 6'b000010,
        PH_LENGTH  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_CHECK   = 6'b010000,
        PH_END     = 6'b100000
    } phase_t;

endpackage

// ===== design/serial_frame_receiver.sv =====
// Framed serial receiver: one received byte per cycle, payload bytes and a
// frame status are delivered through a registered output.
// Depends on sfr_pkg.
// A result appears in the output register in the cycle after its byte is
// accepted. Throughput: one byte per cycle; the byte is taken whenever the
// output register is empty or is being emptied in the same cycle.
// The per-byte work is marker, length and checksum compares and 8-bit adds.
// Reset clears the parse state to hunting, the frame fields and configuration
// registers to zero, and empties the output register; its payload is not reset.
`timescale 1ns / 1ps

module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    // Result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    result_kind,
    output logic [BYTE_W-1:0]    byte_value,
    output logic [BYTE_W-1:0]    byte_index,
    output logic                 last_payload,
    output logic [BYTE_W-1:0]    frame_type,
    output logic [BYTE_W-1:0]    frame_length,
    output logic [BYTE_W-1:0]    computed_checksum
);

    // Configuration registers
    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    logic              adds_type_reg;

    // Parse state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] rx_sum_reg, rx_sum_next;

    // Output register
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic [BYTE_W-1:0] index_reg, index_next;
    logic              last_reg, last_next;
    logic [BYTE_W-1:0] otype_reg;
    logic [BYTE_W-1:0] olength_reg;
    logic [BYTE_W-1:0] osum_reg, osum_next;

    logic              accept;
    logic              emit;
    logic [BYTE_W-1:0] check_sum;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Expected checksum of the frame held so far, used for the status verdict.
    assign check_sum = sum_reg + (adds_type_reg ? type_reg : '0);

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= '0;
            end_marker_reg   <= '0;
            adds_type_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_START_MARKER)
                start_marker_reg <= cfg_data;
            else if (cfg_index == REG_END_MARKER)
                end_marker_reg <= cfg_data;
            else if (cfg_index == REG_ADDS_TYPE)
                adds_type_reg <= cfg_data[0];
        end
    end

    // Per-byte parse step.
    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        rx_sum_next = rx_sum_reg;
        emit        = 1'b0;
        kind_next   = KIND_PAYLOAD;
        value_next  = rx_byte;
        index_next  = '0;
        last_next   = 1'b0;

        unique case (phase_reg)
            PH_TYPE:
            begin
                type_next  = rx_byte;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                length_next = rx_byte;
                count_next  = '0;
                sum_next    = '0;
                phase_next  = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                emit       = 1'b1;
                index_next = count_reg;
                sum_next   = sum_reg + rx_byte;
                count_next = count_reg + 1'b1;
                if (count_next == length_reg)
                begin
                    last_next  = 1'b1;
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                rx_sum_next = rx_byte;
                phase_next  = PH_END;
            end
            PH_END:
            begin
                emit       = 1'b1;
                value_next = rx_sum_reg;
                phase_next = PH_HUNT;
                // A wrong end marker wins over the checksum verdict.
                if (rx_byte != end_marker_reg)
                    kind_next = KIND_NO_END;
                else if (rx_sum_reg == check_sum)
                    kind_next = KIND_ACCEPTED;
                else
                    kind_next = KIND_BAD_SUM;
            end
            default:
            begin
                // Hunting: only the start marker opens a frame.
                phase_next = PH_HUNT;
                if (rx_byte == start_marker_reg)
                begin
                    phase_next  = PH_TYPE;
                    type_next   = '0;
                    length_next = '0;
                    count_next  = '0;
                    sum_next    = '0;
                    rx_sum_next = '0;
                end
            end
        endcase
    end

    // Expected checksum as reported with a result.
    always_comb
    begin
        osum_next = sum_next + (adds_type_reg ? type_next : '0);
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            type_reg   <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            rx_sum_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            rx_sum_reg <= rx_sum_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= emit;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload, loaded only when a result is produced.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg    <= kind_next;
            value_reg   <= value_next;
            index_reg   <= index_next;
            last_reg    <= last_next;
            otype_reg   <= type_next;
            olength_reg <= length_next;
            osum_reg    <= osum_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = kind_reg;
    assign byte_value        = value_reg;
    assign byte_index        = index_reg;
    assign last_payload      = last_reg;
    assign frame_type        = otype_reg;
    assign frame_length      = olength_reg;
    assign computed_checksum = osum_reg;

    // A byte taken in the payload phase always yields a payload item.
    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_PAYLOAD |=> out_valid && result_kind == KIND_PAYLOAD)
        else $error("payload byte produced no payload item");

    // A byte taken at the end-marker position always yields a status item.
    a_status_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_END |=> out_valid && result_kind != KIND_PAYLOAD)
        else $error("end position produced no status item");

    // The last payload item sits at the final index of the announced length.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_payload |->
            result_kind == KIND_PAYLOAD && byte_index == frame_length - 8'd1)
        else $error("last payload mark at wrong index");

    // Status items carry index zero and no last mark.
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_PAYLOAD |-> byte_index == '0 && !last_payload)
        else $error("status item with payload position fields");

endmodule
